@@ sv/rsdk_pkg.sv @@
// Shared types and constants for the derived-key record sorter.
package rsdk_pkg;

   localparam int BASE_W  = 24;
   localparam int TAG_W   = 8;
   localparam int ALLOW_W = 21;
   localparam int DED_W   = 20;
   localparam int KEY_W   = 25;

   // floor(x/10) = (x * ceil(2^27/10)) >> 27, exact for every 24-bit x
   localparam int               DIV10_SHIFT = 27;
   localparam logic [BASE_W-1:0] DIV10_MULT = 24'hCCCCCD;
   localparam int               PROD_W      = 2 * BASE_W;

   localparam int MAX_RECORDS_DEF = 8;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [BASE_W-1:0]  base;
      logic [ALLOW_W-1:0] allowance;
      logic [DED_W-1:0]   deduction;
      logic [KEY_W-1:0]   key;
   } rec_data_type;

   typedef struct packed {
      logic         valid;
      rec_data_type data;
   } record_type;

   // Per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // place the broadcast record in sorted position
      logic emit;     // shift every cell one place toward the head
   } cell_ctl_type;

   typedef enum logic [0:0] {
      ST_LOAD,
      ST_EMIT
   } state_type;

endpackage

@@ sv/rsdk_derive.sv @@
// Front stage: registers an incoming record and derives allowance, deduction and key.
module rsdk_derive (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [rsdk_pkg::BASE_W-1:0] base_amount,
   input  logic [rsdk_pkg::TAG_W-1:0]  record_tag,
   input  logic                        last_record,
   output rsdk_pkg::record_type        rec,
   output logic                        last
);
   import rsdk_pkg::*;

   logic                  s1_valid_ff, s1_valid_in;
   logic [BASE_W-1:0]     s1_base_ff;
   logic [TAG_W-1:0]      s1_tag_ff;
   logic                  s1_last_ff;
   logic [PROD_W-1:0]     s1_prod_ff, s1_prod_in;
   logic [ALLOW_W-1:0]    allowance;
   logic [DED_W-1:0]      deduction;
   logic [KEY_W-1:0]      key;

   // reciprocal multiply for the divide by ten
   always_comb begin
      s1_valid_in = load;
      s1_prod_in  = {{BASE_W{1'b0}}, base_amount} * {{BASE_W{1'b0}}, DIV10_MULT};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_base_ff <= base_amount;
         s1_tag_ff  <= record_tag;
         s1_last_ff <= last_record;
         s1_prod_ff <= s1_prod_in;
      end
   end

   // divide by twenty is half of the divide by ten, rounded down
   always_comb begin
      allowance = s1_prod_ff[DIV10_SHIFT +: ALLOW_W];
      deduction = allowance[ALLOW_W-1:1];
      key       = {1'b0, s1_base_ff} + {{(KEY_W-ALLOW_W){1'b0}}, allowance}
                  - {{(KEY_W-DED_W){1'b0}}, deduction};
   end

   always_comb begin
      rec.valid          = s1_valid_ff;
      rec.data.tag       = s1_tag_ff;
      rec.data.base      = s1_base_ff;
      rec.data.allowance = allowance;
      rec.data.deduction = deduction;
      rec.data.key       = key;
      last               = s1_valid_ff & s1_last_ff;
   end

endmodule

@@ sv/rsdk_cell.sv @@
// One cell of the sorting chain: holds a record, inserts in order, shifts out on emit.
module rsdk_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rsdk_pkg::cell_ctl_type ctl,
   input  rsdk_pkg::record_type   new_rec,
   input  rsdk_pkg::record_type   prev_rec,
   input  logic                   prev_shift,
   input  rsdk_pkg::record_type   next_rec,
   output rsdk_pkg::record_type   rec,
   output logic                   shift
);
   import rsdk_pkg::*;

   logic         valid_ff, valid_in;
   rec_data_type data_ff, data_in;

   // a held record stays put only if its key is at least the new one (keeps ties stable)
   assign shift = !(valid_ff && (data_ff.key >= new_rec.data.key));

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctl.emit) begin
         valid_in = next_rec.valid;
         data_in  = next_rec.data;
      end else if (ctl.insert && shift) begin
         if (prev_shift) begin
            valid_in = prev_rec.valid;
            data_in  = prev_rec.data;
         end else begin
            valid_in = 1'b1;
            data_in  = new_rec.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rec = '{valid: valid_ff, data: data_ff};

endmodule

@@ sv/record_sort_by_derived_key_core.sv @@
// Top level of the derived-key record sorter: front stage, cell chain and control.
//
// Records load one per cycle while req_ready is high: each accepted record
// is registered in the front stage (divide-by-ten multiply) and then
// inserted into a chain of MAX_RECORDS cells, each of which compares its
// key with the broadcast key and holds its record, takes the broadcast one
// or takes its neighbor's, so the chain stays sorted largest key first with
// ties in arrival order. After the record marked last is accepted, req_ready
// drops while that record reaches the chain and stays low while the set
// streams out of the head cell, one record per cycle while rsp_ready is
// high. Records beyond MAX_RECORDS are discarded and every result of that
// set reports rsp_dropped_any.
module record_sort_by_derived_key_core #(
   parameter int MAX_RECORDS = rsdk_pkg::MAX_RECORDS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rsdk_pkg::BASE_W-1:0]  req_base_amount,
   input  logic [rsdk_pkg::TAG_W-1:0]   req_record_tag,
   input  logic                         req_last_record,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rsdk_pkg::TAG_W-1:0]   rsp_out_tag,
   output logic [rsdk_pkg::BASE_W-1:0]  rsp_out_base,
   output logic [rsdk_pkg::ALLOW_W-1:0] rsp_out_allowance,
   output logic [rsdk_pkg::DED_W-1:0]   rsp_out_deduction,
   output logic [rsdk_pkg::KEY_W-1:0]   rsp_out_key,
   output logic                         rsp_dropped_any,
   output logic                         rsp_last_out
);
   import rsdk_pkg::*;

   localparam int CNT_W = $clog2(MAX_RECORDS + 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;

   logic         req_fire, rsp_fire, room;
   record_type   new_rec;
   logic         new_last;
   cell_ctl_type ctl;

   record_type cell_rec   [MAX_RECORDS];
   logic       cell_shift [MAX_RECORDS];

   assign req_fire = req_valid & req_ready;
   assign rsp_fire = rsp_valid & rsp_ready;
   assign room     = (count_ff < CNT_W'(MAX_RECORDS));

   // front stage
   rsdk_derive u_derive (
      .clock       (clock),
      .reset       (reset),
      .load        (req_fire),
      .base_amount (req_base_amount),
      .record_tag  (req_record_tag),
      .last_record (req_last_record),
      .rec         (new_rec),
      .last        (new_last)
   );

   // sorting chain, head at index zero
   for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
      record_type prev_rec, next_rec;
      logic       prev_shift;
      if (i == 0) begin : g_head
         assign prev_rec   = new_rec;
         assign prev_shift = 1'b0;
      end else begin : g_body
         assign prev_rec   = cell_rec[i-1];
         assign prev_shift = cell_shift[i-1];
      end
      if (i == MAX_RECORDS - 1) begin : g_tail
         assign next_rec = '0;
      end else begin : g_mid
         assign next_rec = cell_rec[i+1];
      end
      rsdk_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .new_rec    (new_rec),
         .prev_rec   (prev_rec),
         .prev_shift (prev_shift),
         .next_rec   (next_rec),
         .rec        (cell_rec[i]),
         .shift      (cell_shift[i])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: if (new_last) state_in = ST_EMIT;
         ST_EMIT: if (rsp_fire && rsp_last_out) state_in = ST_LOAD;
         default: state_in = ST_LOAD;
      endcase
   end

   // outputs and chain control
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      ctl.insert = 1'b0;
      ctl.emit   = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready  = !new_last;
            ctl.insert = new_rec.valid & room;
         end
         ST_EMIT: begin
            rsp_valid = cell_rec[0].valid;
            ctl.emit  = rsp_fire;
         end
         default: ;
      endcase
   end

   // set bookkeeping
   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (ctl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (new_rec.valid && !room) begin
         overflow_in = 1'b1;
      end
      if (rsp_fire && rsp_last_out) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_out_tag       = cell_rec[0].data.tag;
   assign rsp_out_base      = cell_rec[0].data.base;
   assign rsp_out_allowance = cell_rec[0].data.allowance;
   assign rsp_out_deduction = cell_rec[0].data.deduction;
   assign rsp_out_key       = cell_rec[0].data.key;
   assign rsp_dropped_any   = overflow_ff;
   assign rsp_last_out      = !cell_rec[1].valid;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and output open at once");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECORDS))
      else $error("record count above capacity");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (cell_rec[0].valid && cell_rec[1].valid) |->
         (cell_rec[0].data.key >= cell_rec[1].data.key))
      else $error("chain head out of order");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> cell_rec[0].valid)
      else $error("emitting from an empty chain");

   a_set_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_last_out) |=> (!rsp_valid && count_ff == '0 && !cell_rec[0].valid))
      else $error("chain not empty after final result");

endmodule

@@ test/record_sort_by_derived_key_core_test.sv @@
// Self-checking testbench for record_sort_by_derived_key_core with a stable-sort scoreboard.
`timescale 1ns / 100ps

module record_sort_by_derived_key_core_test;
   import rsdk_pkg::*;

   localparam int SET_CAPACITY = MAX_RECORDS_DEF;
   localparam int RANDOM_ITEMS = 220;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 20;

   // One sorted record as the block should present it
   typedef struct {
      rec_data_type rec;
      logic         dropped;
      logic         last;
   } sorted_result_type;

   // Scoreboard: collects the current set and predicts its sorted emission
   class sorted_record_scoreboard;
      rec_data_type      held[SET_CAPACITY];
      int                held_count;
      logic              overflow;
      sorted_result_type expected_sorted[$];
      int                mismatch_count;

      function new();
         held_count     = 0;
         overflow       = 1'b0;
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_sorted.size();
      endfunction

      // Note one accepted input transaction; on the last one of a set, predict the output run
      function void load_record(logic [BASE_W-1:0] base, logic [TAG_W-1:0] tag, logic last);
         rec_data_type      r;
         rec_data_type      ordered[SET_CAPACITY];
         sorted_result_type e;
         int unsigned       b;
         int                j;
         b           = 32'(base);
         r.tag       = tag;
         r.base      = base;
         r.allowance = ALLOW_W'(b / 10);
         r.deduction = DED_W'(b / 20);
         r.key       = KEY_W'(b + b / 10 - b / 20);
         if (held_count < SET_CAPACITY) begin
            held[held_count] = r;
            held_count++;
         end else begin
            overflow = 1'b1;
         end
         if (last) begin
            // insertion sort; a record passes only strictly smaller keys, so ties keep load order
            for (int i = 0; i < held_count; i++) begin
               j = i;
               while (j > 0 && ordered[j-1].key < held[i].key) begin
                  ordered[j] = ordered[j-1];
                  j--;
               end
               ordered[j] = held[i];
            end
            for (int i = 0; i < held_count; i++) begin
               e.rec     = ordered[i];
               e.dropped = overflow;
               e.last    = (i == held_count - 1);
               expected_sorted.push_back(e);
            end
            held_count = 0;
            overflow   = 1'b0;
         end
      endfunction

      function void compare_field(string name, longint unsigned exp_v, longint unsigned act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_count++;
         end
      endfunction

      // Check one accepted result transaction against the oldest prediction
      function void check_sorted_record(rec_data_type got, logic dropped, logic last);
         sorted_result_type e;
         if (expected_sorted.size() == 0) begin
            $error("unexpected result: tag %0d base %0d", got.tag, got.base);
            mismatch_count++;
            return;
         end
         e = expected_sorted.pop_front();
         compare_field("out_tag", 64'(e.rec.tag), 64'(got.tag));
         compare_field("out_base", 64'(e.rec.base), 64'(got.base));
         compare_field("out_allowance", 64'(e.rec.allowance), 64'(got.allowance));
         compare_field("out_deduction", 64'(e.rec.deduction), 64'(got.deduction));
         compare_field("out_key", 64'(e.rec.key), 64'(got.key));
         compare_field("dropped_any", 64'(e.dropped), 64'(dropped));
         compare_field("last_out", 64'(e.last), 64'(last));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [BASE_W-1:0]    req_base_amount = '0;
   logic [TAG_W-1:0]     req_record_tag = '0;
   logic                 req_last_record = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [TAG_W-1:0]     rsp_out_tag;
   logic [BASE_W-1:0]    rsp_out_base;
   logic [ALLOW_W-1:0]   rsp_out_allowance;
   logic [DED_W-1:0]     rsp_out_deduction;
   logic [KEY_W-1:0]     rsp_out_key;
   logic                 rsp_dropped_any;
   logic                 rsp_last_out;

   sorted_record_scoreboard sb = new();

   int   items_sent = 0;
   int   cycle_count = 0;
   bit   req_burst = 1'b0;
   bit   rsp_burst = 1'b0;
   logic long_hold_pending = 1'b0;
   bit   long_hold_done = 1'b0;
   int   rsp_wait = 0;
   logic [BASE_W-1:0] tie_pool[4];

   record_sort_by_derived_key_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_base_amount   (req_base_amount),
      .req_record_tag    (req_record_tag),
      .req_last_record   (req_last_record),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_out_base      (rsp_out_base),
      .rsp_out_allowance (rsp_out_allowance),
      .rsp_out_deduction (rsp_out_deduction),
      .rsp_out_key       (rsp_out_key),
      .rsp_dropped_any   (rsp_dropped_any),
      .rsp_last_out      (rsp_last_out)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Cycle counter and run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // Result side: per-transaction random stall, one long hold-off when requested
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_sorted_record('{tag: rsp_out_tag, base: rsp_out_base,
                                  allowance: rsp_out_allowance,
                                  deduction: rsp_out_deduction, key: rsp_out_key},
                                rsp_dropped_any, rsp_last_out);
         if ($urandom_range(0, 15) == 0)
            rsp_burst = ~rsp_burst;
         rsp_wait = rsp_burst ? 0 : $urandom_range(0, 19);
      end
      if (long_hold_pending && !long_hold_done) begin
         rsp_wait       = LONG_HOLD;
         long_hold_done = 1'b1;
      end
      if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Offer one record after a random gap (none in burst mode) and wait until it is taken
   task automatic send_record(logic [BASE_W-1:0] base, logic [TAG_W-1:0] tag, logic last);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_base_amount <= base;
      req_record_tag  <= tag;
      req_last_record <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.load_record(base, tag, last);
      items_sent++;
   endtask

   // One set of n records with a random value style
   task automatic send_random_set(int n);
      int                style;
      logic [BASE_W-1:0] base;
      style = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
         case (style)
            0: base = BASE_W'($urandom());
            1: base = BASE_W'($urandom_range(0, 255));
            2: base = tie_pool[2'($urandom_range(0, 3))];
            default: base = BASE_W'(32'hFFFFFF - $urandom_range(0, 4095));
         endcase
         send_record(base, TAG_W'($urandom()), i == n - 1);
      end
   endtask

   // Idle the input and wait until every predicted result has been checked
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic random_sets(int item_goal);
      int n;
      while (items_sent < item_goal) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
         req_burst = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 4; k++)
            tie_pool[k] = BASE_W'($urandom());
         send_random_set(n);
         if ($urandom_range(0, 7) == 0)
            wait_for_drain();
      end
      req_burst = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // extremes of the base field and tags
      send_record(24'hFFFFFF, 8'h00, 1'b0);
      send_record(24'h000000, 8'hFF, 1'b1);
      // set of a single record
      send_record(24'd19, 8'hA5, 1'b1);
      // equal keys keep load order
      send_record(24'd1000, 8'd1, 1'b0);
      send_record(24'd1000, 8'd2, 1'b0);
      send_record(24'd5000, 8'd3, 1'b0);
      send_record(24'd1000, 8'd4, 1'b1);
      // store full: two records dropped, the last one among them
      for (int i = 0; i < 10; i++)
         send_record(24'(i * 37 + 9), 8'(16 + i), i == 9);
      // exactly full set with alternating bit patterns
      for (int i = 0; i < SET_CAPACITY; i++)
         send_record(i[0] ? 24'hAAAAAA : 24'h555555 + 24'(i), 8'(i[0] ? 8'h55 : 8'hAA),
                     i == SET_CAPACITY - 1);

      random_sets(RANDOM_ITEMS - 30);

      // back pressure: receiver holds off while full sets are offered back to back
      wait_for_drain();
      long_hold_pending <= 1'b1;
      req_burst = 1'b1;
      for (int s = 0; s < 3; s++) begin
         for (int k = 0; k < 4; k++)
            tie_pool[k] = BASE_W'($urandom());
         send_random_set(SET_CAPACITY);
      end
      req_burst = 1'b0;

      random_sets(RANDOM_ITEMS);
      req_valid <= 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
